// File: design/psfs_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the particulate sensor frame scanner.
// No dependencies.
package psfs_pkg;

	localparam int unsigned WinLen    = 24;
	localparam int unsigned RespLen   = 9;
	localparam int unsigned UploadLen = 24;

	// frame_kind register codes
	typedef enum logic [1:0] {
		KIND_SLEEP_WAKE = 2'd0,
		KIND_QUERY      = 2'd1,
		KIND_UPLOAD     = 2'd2,
		KIND_UNUSED     = 2'd3
	} frame_kind_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_DEV_FAIL = 2'd1,
		ST_NO_FRAME = 2'd2,
		ST_SHORT    = 2'd3
	} status_t;

	// register byte addresses
	localparam logic [1:0] ADDR_FRAME_KIND = 2'd0;

	localparam logic [7:0] RESP_START = 8'hff;
	localparam logic [7:0] ID_SLEEP   = 8'ha7;
	localparam logic [7:0] ID_MEAS    = 8'h86;
	localparam logic [7:0] UPL_START0 = 8'h42;
	localparam logic [7:0] UPL_START1 = 8'h4d;
	localparam logic [7:0] RET_FAIL   = 8'h00;

	// result item as packed on the output bus, status in the low bits
	typedef struct packed {
		logic [15:0] pm10;
		logic [15:0] pm2_5;
		logic [15:0] pm1;
		status_t     status;
	} result_t;

endpackage

// File: design/particulate_sensor_frame_scanner.sv
`timescale 1ns / 1ps
// Particulate sensor frame scanner: top level, single module.
// Depends on psfs_pkg.
//
// Takes received sensor UART bytes on the s_ side, one per cycle unless stalled, each read ending
// with s_tlast, and reports the first valid frame of the kind selected by frame_kind
// (register at byte address 0: 0 sleep/wake response, 1 queried measurement response,
// 2 active upload frame). A 9-byte response is 0xff, id, six data bytes and the negated
// 8-bit sum of bytes 1..7; a 24-byte upload frame is 0x42 0x4d ... with a big-endian
// 16-bit sum of bytes 0..21 at the end. At most one result per read: the frame's status
// and PM values as soon as its last byte arrives, or, at the end of a read without a
// frame, "too short" (fewer bytes than the frame length) or "no frame". Throughput is
// one byte per cycle while m_ does not stall; a taken byte waits in the input stage and
// its result goes into the result register. The cost per byte is set by the frame
// check between the input stage and the result register: the window checksums are
// kept as running sums, so that path is one 16-bit compare and some byte compares. A
// result waiting in the output register does not stop intake until the input stage
// also holds a byte. Write configuration only while the block is idle; the block does not enforce it.
module particulate_sensor_frame_scanner (
	input  logic        clk,
	input  logic        arst_n,
	// byte input
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  logic        s_tlast,   // last_of_read
	// result output
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // [1:0] status, [17:2] pm1, [33:18] pm2_5, [49:34] pm10
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// ---------------- configuration register ----------------
	psfs_pkg::frame_kind_t frame_kind_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_kind_q <= psfs_pkg::KIND_QUERY;
		end else if (psel && penable && pwrite && pready &&
		             paddr == psfs_pkg::ADDR_FRAME_KIND) begin
			frame_kind_q <= psfs_pkg::frame_kind_t'(pwdata[1:0]);
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr == psfs_pkg::ADDR_FRAME_KIND)
			prdata = {30'd0, frame_kind_q};
	end

	// ---------------- input stage and byte window ----------------
	// window_q[23] is the newest byte. The window shifts when a byte is taken,
	// so in stage 1 it already includes the byte held there.
	logic [7:0]  window_q [psfs_pkg::WinLen];
	logic [15:0] sum22_q;   // 16-bit sum of window bytes 0..21
	logic [7:0]  sum7_q;    // 8-bit sum of window bytes 16..22
	logic        valid_s1;
	logic        last_s1;
	logic        advance;
	logic        in_acc;

	assign advance  = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign in_acc   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < psfs_pkg::WinLen; i++)
				window_q[i] <= '0;
			sum22_q <= '0;
			sum7_q  <= '0;
		end else if (in_acc) begin
			for (int i = 0; i < psfs_pkg::WinLen - 1; i++)
				window_q[i] <= window_q[i+1];
			window_q[psfs_pkg::WinLen-1] <= s_tdata;
			// running sums: byte entering the span minus byte leaving it
			sum22_q <= sum22_q + {8'd0, window_q[22]} - {8'd0, window_q[0]};
			sum7_q  <= sum7_q + window_q[23] - window_q[16];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc)
			last_s1 <= s_tlast;
	end

	// ---------------- per-read state ----------------
	logic [4:0] bytes_seen_q;
	logic       frame_reported_q;
	logic [4:0] seen_now;

	assign seen_now = (bytes_seen_q == 5'(psfs_pkg::WinLen)) ? bytes_seen_q
	                                                         : bytes_seen_q + 5'd1;

	// ---------------- frame check ----------------
	logic           resp_kind;
	logic [7:0]     resp_id;
	logic           resp_hit;
	logic           upl_hit;
	logic           hit;
	logic           emit;
	logic [4:0]     kind_len;
	psfs_pkg::result_t res;

	assign resp_kind = (frame_kind_q == psfs_pkg::KIND_SLEEP_WAKE) ||
	                   (frame_kind_q == psfs_pkg::KIND_QUERY);
	assign resp_id   = (frame_kind_q == psfs_pkg::KIND_SLEEP_WAKE) ? psfs_pkg::ID_SLEEP
	                                                               : psfs_pkg::ID_MEAS;
	assign kind_len  = (frame_kind_q == psfs_pkg::KIND_UPLOAD) ? 5'(psfs_pkg::UploadLen)
	                                                           : 5'(psfs_pkg::RespLen);

	// response frame occupies window bytes 15..23
	assign resp_hit = resp_kind && (seen_now >= 5'(psfs_pkg::RespLen)) &&
	                  window_q[15] == psfs_pkg::RESP_START && window_q[16] == resp_id &&
	                  (8'd0 - sum7_q) == window_q[23];

	// upload frame fills the whole window
	assign upl_hit = (frame_kind_q == psfs_pkg::KIND_UPLOAD) &&
	                 (seen_now == 5'(psfs_pkg::UploadLen)) &&
	                 window_q[0] == psfs_pkg::UPL_START0 &&
	                 window_q[1] == psfs_pkg::UPL_START1 &&
	                 {window_q[22], window_q[23]} == sum22_q;

	assign hit  = !frame_reported_q && (resp_hit || upl_hit);
	assign emit = hit || (!frame_reported_q && last_s1);

	always_comb begin
		res.status = psfs_pkg::ST_NO_FRAME;
		res.pm1    = '0;
		res.pm2_5  = '0;
		res.pm10   = '0;
		if (hit) begin
			res.status = psfs_pkg::ST_OK;
			case (frame_kind_q)
				psfs_pkg::KIND_SLEEP_WAKE: begin
					if (window_q[17] == psfs_pkg::RET_FAIL)
						res.status = psfs_pkg::ST_DEV_FAIL;
				end
				psfs_pkg::KIND_QUERY: begin
					res.pm1   = {window_q[21], window_q[22]};
					res.pm2_5 = {window_q[17], window_q[18]};
					res.pm10  = {window_q[19], window_q[20]};
				end
				psfs_pkg::KIND_UPLOAD: begin
					res.pm1   = {window_q[10], window_q[11]};
					res.pm2_5 = {window_q[12], window_q[13]};
					res.pm10  = {window_q[14], window_q[15]};
				end
				default: ;
			endcase
		end else if (seen_now < kind_len) begin
			res.status = psfs_pkg::ST_SHORT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_seen_q     <= '0;
			frame_reported_q <= 1'b0;
		end else if (advance) begin
			if (last_s1) begin
				// no frame spans two reads
				bytes_seen_q     <= '0;
				frame_reported_q <= 1'b0;
			end else begin
				bytes_seen_q     <= seen_now;
				frame_reported_q <= frame_reported_q || hit;
			end
		end
	end

	// ---------------- result register ----------------
	psfs_pkg::result_t res_q;
	logic              out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= emit;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit)
			res_q <= res;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, res_q};

	// ---------------- assertions ----------------
	a_seen_bound: assert property (@(posedge clk) disable iff (!arst_n)
		bytes_seen_q <= 5'(psfs_pkg::WinLen))
		else $error("bytes_seen beyond window length");

	a_read_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && last_s1 |=> bytes_seen_q == 5'd0 && !frame_reported_q)
		else $error("per-read state not cleared at end of read");

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> valid_s1 && m_tvalid && !m_tready)
		else $error("input stalled without a blocked item");

	a_non_ok_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res_q.status != psfs_pkg::ST_OK |->
			res_q.pm1 == 16'd0 && res_q.pm2_5 == 16'd0 && res_q.pm10 == 16'd0)
		else $error("non-ok result carries values");

endmodule
